[hdl/ecd_pkg.sv]
// Shared constants for the epoch-seconds to civil date/time converter.
// Holds field widths, reciprocal multipliers for the constant divides and the month table.
// No dependencies.
package ecd_pkg;

    localparam int SECS_W   = 32;
    localparam int YEAR_W   = 12;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;

    // Seconds per day is 675 * 2^7: peel the low 7 bits, then divide by 675.
    localparam int          DAY_LO_W = 7;
    localparam int          DAY_DIV  = 675;
    localparam int          DAY_SH   = 35;
    localparam logic [25:0] DAY_MUL  =
        26'(((64'd1 << DAY_SH) + 64'(DAY_DIV) - 64'd1) / 64'(DAY_DIV));

    // Shift to the 0000-03-01 epoch. Inputs only reach eras 4 and 5.
    localparam int DAYS_SHIFT   = 719468;
    localparam int DAYS_PER_ERA = 146097;
    localparam int ERA5_START   = 5 * DAYS_PER_ERA - DAYS_SHIFT;
    localparam int ERA4_OFFSET  = DAYS_SHIFT - 4 * DAYS_PER_ERA;
    localparam int ERA4_YEAR    = 4 * 400;
    localparam int ERA5_YEAR    = 5 * 400;

    localparam int          Q1460_DIV = 1460;
    localparam int          Q1460_SH  = 29;
    localparam logic [18:0] Q1460_MUL =
        19'(((64'd1 << Q1460_SH) + 64'(Q1460_DIV) - 64'd1) / 64'(Q1460_DIV));

    localparam int CENT_DAYS = 36524;
    localparam int ERA_LAST  = 146096;

    localparam int          YEAR_DAYS = 365;
    localparam int          YOE_SH    = 27;
    localparam logic [18:0] YOE_MUL   =
        19'(((64'd1 << YOE_SH) + 64'(YEAR_DAYS) - 64'd1) / 64'(YEAR_DAYS));

    localparam int          MP_DIV = 153;
    localparam int          MP_SH  = 19;
    localparam logic [11:0] MP_MUL =
        12'(((64'd1 << MP_SH) + 64'(MP_DIV) - 64'd1) / 64'(MP_DIV));

    localparam int          SECS_PER_HOUR = 3600;
    localparam int          HOUR_SH       = 29;
    localparam logic [17:0] HOUR_MUL      =
        18'(((64'd1 << HOUR_SH) + 64'(SECS_PER_HOUR) - 64'd1) / 64'(SECS_PER_HOUR));

    localparam int          SECS_PER_MIN = 60;
    localparam int          MIN_SH       = 18;
    localparam logic [12:0] MIN_MUL      =
        13'(((64'd1 << MIN_SH) + 64'(SECS_PER_MIN) - 64'd1) / 64'(SECS_PER_MIN));

    // First day of each March-based month within the year: (153 * mp + 2) / 5.
    function automatic logic [8:0] mp_day_offset(input logic [3:0] mp);
        logic [8:0] off;
        case (mp)
            4'd0:    off = 9'd0;
            4'd1:    off = 9'd31;
            4'd2:    off = 9'd61;
            4'd3:    off = 9'd92;
            4'd4:    off = 9'd122;
            4'd5:    off = 9'd153;
            4'd6:    off = 9'd184;
            4'd7:    off = 9'd214;
            4'd8:    off = 9'd245;
            4'd9:    off = 9'd275;
            4'd10:   off = 9'd306;
            4'd11:   off = 9'd337;
            default: off = 9'd0;
        endcase
        return off;
    endfunction

endpackage

[hdl/ecd_if.sv]
// Valid/ready channels of the epoch-seconds to civil date/time converter.
// Depends on ecd_pkg for field widths.
interface ecd_stamp_if;
    logic                         valid;
    logic                         ready;
    logic [ecd_pkg::SECS_W-1:0]   epoch_seconds;

    modport source (output valid, output epoch_seconds, input ready);
    modport sink   (input valid, input epoch_seconds, output ready);
endinterface

interface ecd_civil_if;
    logic                          valid;
    logic                          ready;
    logic [ecd_pkg::YEAR_W-1:0]    year;
    logic [ecd_pkg::MONTH_W-1:0]   month;
    logic [ecd_pkg::DAY_W-1:0]     day;
    logic [ecd_pkg::HOUR_W-1:0]    hour;
    logic [ecd_pkg::MINUTE_W-1:0]  minute;
    logic [ecd_pkg::SECOND_W-1:0]  second;

    modport source (output valid, output year, output month, output day,
                    output hour, output minute, output second, input ready);
    modport sink   (input valid, input year, input month, input day,
                    input hour, input minute, input second, output ready);
endinterface

[hdl/epoch_seconds_to_civil_datetime_core.sv]
// Throughput: one word per cycle while the output is not stalled; eight register stages,
// each about one constant-reciprocal multiply plus a short add/compare chain deep, with
// per-stage ready so bubbles close up.
// Reset (rst_n, asynchronous, active low) clears the stage valid bits; data regs are unreset.
// Depends on ecd_pkg and the channel interfaces in ecd_if.sv.
module epoch_seconds_to_civil_datetime_core (
    input  logic              clk,
    input  logic              rst_n,
    ecd_stamp_if.sink         stamp,
    ecd_civil_if.source       civil
);
    import ecd_pkg::*;

    localparam int NSTG = 8;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] en;

    // Stage 0: days = secs / 86400 by reciprocal multiply.
    logic [24:0] s0_x_next;
    logic [50:0] s0_prod;
    logic [15:0] s0_days_next;
    logic [24:0] s0_x_reg;
    logic [6:0]  s0_lo_reg;
    logic [15:0] s0_days_reg;

    // Stage 1: second of day and day of era.
    logic [24:0] s1_mul;
    logic [24:0] s1_rem;
    logic [16:0] s1_sod_next;
    logic [17:0] s1_doe_next;
    logic        s1_era5_next;
    logic [16:0] s1_sod_reg;
    logic [17:0] s1_doe_reg;
    logic        s1_era5_reg;

    // Stage 2: leap corrections and hour.
    logic [36:0] s2_p1460;
    logic [34:0] s2_phour;
    logic [6:0]  s2_q1460_next;
    logic [2:0]  s2_qcent_next;
    logic        s2_qlast_next;
    logic [4:0]  s2_hour_next;
    logic [6:0]  s2_q1460_reg;
    logic [2:0]  s2_qcent_reg;
    logic        s2_qlast_reg;
    logic [4:0]  s2_hour_reg;
    logic [17:0] s2_doe_reg;
    logic        s2_era5_reg;
    logic [16:0] s2_sod_reg;

    // Stage 3: numerator for year of era, second within hour.
    logic [17:0] s3_num_next;
    logic [16:0] s3_hmul;
    logic [11:0] s3_rem_next;
    logic [17:0] s3_num_reg;
    logic [11:0] s3_rem_reg;
    logic [17:0] s3_doe_reg;
    logic        s3_era5_reg;
    logic [4:0]  s3_hour_reg;

    // Stage 4: year of era, minute.
    logic [36:0] s4_pyoe;
    logic [24:0] s4_pmin;
    logic [8:0]  s4_yoe_next;
    logic [5:0]  s4_min_next;
    logic [8:0]  s4_yoe_reg;
    logic [5:0]  s4_min_reg;
    logic [11:0] s4_rem_reg;
    logic [17:0] s4_doe_reg;
    logic        s4_era5_reg;
    logic [4:0]  s4_hour_reg;

    // Stage 5: day of year, second.
    logic [1:0]  s5_y100;
    logic [17:0] s5_ydays;
    logic [17:0] s5_doy_full;
    logic [8:0]  s5_doy_next;
    logic [11:0] s5_smul;
    logic [5:0]  s5_sec_next;
    logic [8:0]  s5_doy_reg;
    logic [5:0]  s5_sec_reg;
    logic [8:0]  s5_yoe_reg;
    logic        s5_era5_reg;
    logic [4:0]  s5_hour_reg;
    logic [5:0]  s5_min_reg;

    // Stage 6: March-based month index.
    logic [10:0] s6_mx;
    logic [22:0] s6_pmp;
    logic [3:0]  s6_mp_next;
    logic [3:0]  s6_mp_reg;
    logic [8:0]  s6_doy_reg;
    logic [8:0]  s6_yoe_reg;
    logic        s6_era5_reg;
    logic [4:0]  s6_hour_reg;
    logic [5:0]  s6_min_reg;
    logic [5:0]  s6_sec_reg;

    // Stage 7: output word.
    logic [MONTH_W-1:0]  s7_month_next;
    logic [DAY_W-1:0]    s7_day_next;
    logic [YEAR_W-1:0]   s7_year_next;
    logic [YEAR_W-1:0]   s7_base;
    logic [8:0]          s7_dsub;
    logic [YEAR_W-1:0]   year_reg;
    logic [MONTH_W-1:0]  month_reg;
    logic [DAY_W-1:0]    day_reg;
    logic [HOUR_W-1:0]   hour_reg;
    logic [MINUTE_W-1:0] minute_reg;
    logic [SECOND_W-1:0] second_reg;

    // A stage advances when it is empty or the stage after it advances.
    always_comb
    begin
        en[NSTG-1] = !vld_reg[NSTG-1] || civil.ready;
        for (int i = NSTG - 2; i >= 0; i--)
        begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    assign stamp.ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= stamp.valid;
            end
            for (int i = 1; i < NSTG; i++)
            begin
                if (en[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // ---------------- stage 0
    always_comb
    begin
        s0_x_next    = stamp.epoch_seconds[SECS_W-1:DAY_LO_W];
        s0_prod      = 51'(s0_x_next) * 51'(DAY_MUL);
        s0_days_next = 16'(s0_prod >> DAY_SH);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s0_x_reg    <= s0_x_next;
            s0_lo_reg   <= stamp.epoch_seconds[DAY_LO_W-1:0];
            s0_days_reg <= s0_days_next;
        end
    end

    // ---------------- stage 1
    always_comb
    begin
        s1_mul      = 25'(s0_days_reg) * 25'(DAY_DIV);
        s1_rem      = s0_x_reg - s1_mul;
        s1_sod_next = {s1_rem[9:0], s0_lo_reg};
        s1_era5_next = (s0_days_reg >= 16'(ERA5_START));
        if (s1_era5_next)
        begin
            s1_doe_next = 18'(s0_days_reg) - 18'(ERA5_START);
        end
        else
        begin
            s1_doe_next = 18'(s0_days_reg) + 18'(ERA4_OFFSET);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s1_sod_reg  <= s1_sod_next;
            s1_doe_reg  <= s1_doe_next;
            s1_era5_reg <= s1_era5_next;
        end
    end

    // ---------------- stage 2
    always_comb
    begin
        s2_p1460      = 37'(s1_doe_reg) * 37'(Q1460_MUL);
        s2_q1460_next = 7'(s2_p1460 >> Q1460_SH);
        s2_qcent_next = 3'(s1_doe_reg >= 18'(CENT_DAYS))
                      + 3'(s1_doe_reg >= 18'(2 * CENT_DAYS))
                      + 3'(s1_doe_reg >= 18'(3 * CENT_DAYS))
                      + 3'(s1_doe_reg >= 18'(4 * CENT_DAYS));
        s2_qlast_next = (s1_doe_reg >= 18'(ERA_LAST));
        s2_phour      = 35'(s1_sod_reg) * 35'(HOUR_MUL);
        s2_hour_next  = 5'(s2_phour >> HOUR_SH);
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s2_q1460_reg <= s2_q1460_next;
            s2_qcent_reg <= s2_qcent_next;
            s2_qlast_reg <= s2_qlast_next;
            s2_hour_reg  <= s2_hour_next;
            s2_doe_reg   <= s1_doe_reg;
            s2_era5_reg  <= s1_era5_reg;
            s2_sod_reg   <= s1_sod_reg;
        end
    end

    // ---------------- stage 3
    always_comb
    begin
        s3_num_next = s2_doe_reg - 18'(s2_q1460_reg) + 18'(s2_qcent_reg)
                    - 18'(s2_qlast_reg);
        s3_hmul     = 17'(s2_hour_reg) * 17'(SECS_PER_HOUR);
        s3_rem_next = 12'(s2_sod_reg - s3_hmul);
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            s3_num_reg  <= s3_num_next;
            s3_rem_reg  <= s3_rem_next;
            s3_doe_reg  <= s2_doe_reg;
            s3_era5_reg <= s2_era5_reg;
            s3_hour_reg <= s2_hour_reg;
        end
    end

    // ---------------- stage 4
    always_comb
    begin
        s4_pyoe     = 37'(s3_num_reg) * 37'(YOE_MUL);
        s4_yoe_next = 9'(s4_pyoe >> YOE_SH);
        s4_pmin     = 25'(s3_rem_reg) * 25'(MIN_MUL);
        s4_min_next = 6'(s4_pmin >> MIN_SH);
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            s4_yoe_reg  <= s4_yoe_next;
            s4_min_reg  <= s4_min_next;
            s4_rem_reg  <= s3_rem_reg;
            s4_doe_reg  <= s3_doe_reg;
            s4_era5_reg <= s3_era5_reg;
            s4_hour_reg <= s3_hour_reg;
        end
    end

    // ---------------- stage 5
    always_comb
    begin
        s5_y100     = 2'(s4_yoe_reg >= 9'd100) + 2'(s4_yoe_reg >= 9'd200)
                    + 2'(s4_yoe_reg >= 9'd300);
        s5_ydays    = 18'(s4_yoe_reg) * 18'(YEAR_DAYS) + 18'(s4_yoe_reg >> 2)
                    - 18'(s5_y100);
        s5_doy_full = s4_doe_reg - s5_ydays;
        s5_doy_next = s5_doy_full[8:0];
        s5_smul     = 12'(s4_min_reg) * 12'(SECS_PER_MIN);
        s5_sec_next = 6'(s4_rem_reg - s5_smul);
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            s5_doy_reg  <= s5_doy_next;
            s5_sec_reg  <= s5_sec_next;
            s5_yoe_reg  <= s4_yoe_reg;
            s5_era5_reg <= s4_era5_reg;
            s5_hour_reg <= s4_hour_reg;
            s5_min_reg  <= s4_min_reg;
        end
    end

    // ---------------- stage 6
    always_comb
    begin
        s6_mx      = 11'(s5_doy_reg) * 11'd5 + 11'd2;
        s6_pmp     = 23'(s6_mx) * 23'(MP_MUL);
        s6_mp_next = 4'(s6_pmp >> MP_SH);
    end

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            s6_mp_reg   <= s6_mp_next;
            s6_doy_reg  <= s5_doy_reg;
            s6_yoe_reg  <= s5_yoe_reg;
            s6_era5_reg <= s5_era5_reg;
            s6_hour_reg <= s5_hour_reg;
            s6_min_reg  <= s5_min_reg;
            s6_sec_reg  <= s5_sec_reg;
        end
    end

    // ---------------- stage 7: back from March-based to January-based year
    always_comb
    begin
        if (s6_mp_reg < 4'd10)
        begin
            s7_month_next = s6_mp_reg + 4'd3;
        end
        else
        begin
            s7_month_next = s6_mp_reg - 4'd9;
        end
        s7_dsub     = s6_doy_reg - mp_day_offset(s6_mp_reg) + 9'd1;
        s7_day_next = s7_dsub[DAY_W-1:0];
        s7_base     = s6_era5_reg ? YEAR_W'(ERA5_YEAR) : YEAR_W'(ERA4_YEAR);
        s7_year_next = YEAR_W'(s6_yoe_reg) + s7_base
                     + YEAR_W'(s7_month_next <= 4'd2);
    end

    always_ff @(posedge clk)
    begin
        if (en[7])
        begin
            year_reg   <= s7_year_next;
            month_reg  <= s7_month_next;
            day_reg    <= s7_day_next;
            hour_reg   <= s6_hour_reg;
            minute_reg <= s6_min_reg;
            second_reg <= s6_sec_reg;
        end
    end

    assign civil.valid  = vld_reg[NSTG-1];
    assign civil.year   = year_reg;
    assign civil.month  = month_reg;
    assign civil.day    = day_reg;
    assign civil.hour   = hour_reg;
    assign civil.minute = minute_reg;
    assign civil.second = second_reg;

`ifndef ASSERT_OFF
    a_fields_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        civil.valid |-> (civil.month >= 4'd1 && civil.month <= 4'd12
                         && civil.day >= 5'd1 && civil.day <= 5'd31
                         && civil.hour <= 5'd23 && civil.minute <= 6'd59
                         && civil.second <= 6'd59))
        else $error("civil word field out of range");

    a_year_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        civil.valid |-> (civil.year >= 12'd1970 && civil.year <= 12'd2106))
        else $error("civil year out of range");

    a_day_of_year: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[5] |-> (s5_doy_reg <= 9'd365 && s5_yoe_reg <= 9'd399))
        else $error("day or year of era out of range");

    a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
        (&vld_reg && !civil.ready) |-> !stamp.ready)
        else $error("input taken while pipeline full and output stalled");
`endif

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Testbench for epoch_seconds_to_civil_datetime_core: a directed table of timestamps, then
// random timestamps in four idle/stall mixes; words checked against table or predictor.
// Depends on ecd_pkg and the stamp/civil channel interfaces in hdl/ecd_if.sv.
module tb_top;

    localparam int unsigned SECS_PER_DAY  = 86400;
    localparam int unsigned SECS_PER_HOUR = 3600;
    localparam int unsigned SECS_PER_MIN  = 60;
    localparam int unsigned MARCH0_SHIFT  = 719468;  // 1970-01-01 counted from 0000-03-01
    localparam int unsigned ERA_DAYS      = 146097;
    localparam int unsigned ERA_LAST_DAY  = 146096;
    localparam int unsigned QUAD_DAYS_M1  = 1460;
    localparam int unsigned CENTURY_DAYS  = 36524;
    localparam int unsigned PLAIN_YEAR    = 365;
    localparam int unsigned MONTH_SPAN    = 153;     // days in five March-based months
    localparam int unsigned LAST_DAY      = 49710;   // day index of 2106-02-07

    localparam int N_ROWS        = 20;
    localparam int N_PHASES      = 4;
    localparam int WORDS_PER_PHASE = 250;
    localparam int QUIET_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 24;

    typedef struct packed {
        logic [ecd_pkg::YEAR_W-1:0]   year;
        logic [ecd_pkg::MONTH_W-1:0]  month;
        logic [ecd_pkg::DAY_W-1:0]    day;
        logic [ecd_pkg::HOUR_W-1:0]   hour;
        logic [ecd_pkg::MINUTE_W-1:0] minute;
        logic [ecd_pkg::SECOND_W-1:0] second;
    } civil_t;

    typedef struct packed {
        logic [ecd_pkg::SECS_W-1:0] secs;
        logic                       fixed_want;  // want below is hand-computed
        civil_t                     want;
    } stamp_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    int          n_fail;
    int unsigned quiet_cycles;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    civil_t      civil_expect_q[$];
    stamp_row_t  stamp_table [N_ROWS];

    ecd_stamp_if stamp();
    ecd_civil_if civil();

    epoch_seconds_to_civil_datetime_core u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .stamp (stamp),
        .civil (civil)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic civil_t civil_from_epoch(input logic [ecd_pkg::SECS_W-1:0] secs);
        int unsigned days, sod, z, era, doe, yoe, doy, mp, mon, dom, yr;
        civil_t c;
        days = secs / SECS_PER_DAY;
        sod  = secs % SECS_PER_DAY;
        z    = days + MARCH0_SHIFT;
        era  = z / ERA_DAYS;
        doe  = z - era * ERA_DAYS;
        yoe  = (doe - doe / QUAD_DAYS_M1 + doe / CENTURY_DAYS - doe / ERA_LAST_DAY) / PLAIN_YEAR;
        doy  = doe - (PLAIN_YEAR * yoe + yoe / 4 - yoe / 100);
        mp   = (5 * doy + 2) / MONTH_SPAN;
        mon  = (mp < 10) ? mp + 3 : mp - 9;
        dom  = doy - (MONTH_SPAN * mp + 2) / 5 + 1;
        // January and February belong to the March-based year before
        yr   = yoe + era * 400 + ((mon <= 2) ? 1 : 0);
        c.year   = yr[ecd_pkg::YEAR_W-1:0];
        c.month  = mon[ecd_pkg::MONTH_W-1:0];
        c.day    = dom[ecd_pkg::DAY_W-1:0];
        c.hour   = 5'(sod / SECS_PER_HOUR);
        c.minute = 6'((sod / SECS_PER_MIN) % 60);
        c.second = 6'(sod % 60);
        return c;
    endfunction

    function automatic logic [ecd_pkg::SECS_W-1:0] random_stamp();
        longint unsigned s;
        case ($urandom_range(3))
            0: s = $urandom;
            1:
            begin
                // land on or next to a day boundary, or anywhere within that day
                s = 64'($urandom_range(LAST_DAY)) * SECS_PER_DAY;
                case ($urandom_range(2))
                    0: s = s;
                    1: s = s + SECS_PER_DAY - 1;
                    default: s = s + $urandom_range(SECS_PER_DAY - 1);
                endcase
            end
            2: s = 64'hFFFF_FFFF - $urandom_range(400000);
            default: s = $urandom_range(400000);
        endcase
        if (s > 64'hFFFF_FFFF)
            s = 64'hFFFF_FFFF - $urandom_range(1000);
        return s[ecd_pkg::SECS_W-1:0];
    endfunction

    task automatic send_stamp(input logic [ecd_pkg::SECS_W-1:0] secs,
                              input logic fixed_want, input civil_t want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            stamp.valid <= 1'b0;
            @(posedge clk);
        end
        stamp.valid         <= 1'b1;
        stamp.epoch_seconds <= secs;
        @(posedge clk);
        while (!stamp.ready)
            @(posedge clk);
        civil_expect_q.push_back(fixed_want ? want : civil_from_epoch(secs));
    endtask

    task automatic compare_field(input string name, input logic [11:0] want_v,
                                 input logic [11:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            n_fail++;
        end
    endtask

    always @(posedge clk)
    begin : civil_check
        civil_t want;
        if (rst_n && civil.valid && civil.ready)
        begin
            if (civil_expect_q.size() == 0)
            begin
                $error("civil word %0d-%0d-%0d with nothing outstanding",
                       civil.year, civil.month, civil.day);
                n_fail++;
            end
            else
            begin
                want = civil_expect_q.pop_front();
                compare_field("year",   12'(want.year),   12'(civil.year));
                compare_field("month",  12'(want.month),  12'(civil.month));
                compare_field("day",    12'(want.day),    12'(civil.day));
                compare_field("hour",   12'(want.hour),   12'(civil.hour));
                compare_field("minute", 12'(want.minute), 12'(civil.minute));
                compare_field("second", 12'(want.second), 12'(civil.second));
            end
        end
        civil.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if ((stamp.valid && stamp.ready) || (civil.valid && civil.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        int unsigned idle_mix [N_PHASES];
        int unsigned stall_mix [N_PHASES];
        idle_mix            = '{0, 66, 0, 29};
        stall_mix           = '{0, 0, 66, 29};
        rst_n               = 1'b0;
        n_fail              = 0;
        send_idle_pct       = 0;
        recv_stall_pct      = 0;
        stamp.valid         <= 1'b0;
        stamp.epoch_seconds <= '0;

        stamp_table = '{
            '{32'd0,          1'b1, '{12'd1970, 4'd1, 5'd1, 5'd0,  6'd0,  6'd0}},
            '{32'd59,         1'b1, '{12'd1970, 4'd1, 5'd1, 5'd0,  6'd0,  6'd59}},
            '{32'd3599,       1'b1, '{12'd1970, 4'd1, 5'd1, 5'd0,  6'd59, 6'd59}},
            '{32'd86399,      1'b1, '{12'd1970, 4'd1, 5'd1, 5'd23, 6'd59, 6'd59}},
            '{32'd86400,      1'b1, '{12'd1970, 4'd1, 5'd2, 5'd0,  6'd0,  6'd0}},
            '{32'hFFFF_FFFF,  1'b1, '{12'd2106, 4'd2, 5'd7, 5'd6,  6'd28, 6'd15}},
            '{32'd4294944000, 1'b0, '0},  // start of the last day
            '{32'd2678400,    1'b0, '0},  // first of February 1970
            '{32'd68169600,   1'b0, '0},  // leap day 1972
            '{32'd946684799,  1'b0, '0},  // last second of 1999
            '{32'd951782400,  1'b0, '0},  // leap day of a 400-year
            '{32'd951868799,  1'b0, '0},  // last second of an era
            '{32'd951868800,  1'b0, '0},  // first day of the next era
            '{32'd4107542399, 1'b0, '0},  // 2100 is not leap: Feb 28 ends
            '{32'd4107542400, 1'b0, '0},  // then March 1
            '{32'h7FFF_FFFF,  1'b0, '0},
            '{32'h8000_0000,  1'b0, '0},
            '{32'hAAAA_AAAA,  1'b0, '0},
            '{32'h5555_5555,  1'b0, '0},
            '{32'hFFFE_FFFF,  1'b0, '0}
        };

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_ROWS; i++)
            send_stamp(stamp_table[i].secs, stamp_table[i].fixed_want, stamp_table[i].want);

        for (int p = 0; p < N_PHASES; p++)
        begin
            send_idle_pct  = idle_mix[p];
            recv_stall_pct = stall_mix[p];
            for (int n = 0; n < WORDS_PER_PHASE; n++)
                send_stamp(random_stamp(), 1'b0, '0);
            // hold off until the pipe has drained
            stamp.valid <= 1'b0;
            do
                @(posedge clk);
            while (civil_expect_q.size() != 0);
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (n_fail == 0 && civil_expect_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[filelist.f]
hdl/ecd_pkg.sv
hdl/ecd_if.sv
hdl/epoch_seconds_to_civil_datetime_core.sv
tb/tb_top.sv
